// ===== rtl/pes_pkg.sv =====
// Shared constants and types for the proportional estimate search block.
// No dependencies; compiled first.
package pes_pkg;

  // Default sizes of the element store
  localparam int STORE_DEPTH_DEF   = 1024;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // Fixed field widths of the channels and the register
  localparam int CMD_W   = 1;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;

  localparam logic [COUNT_W-1:0] USED_COUNT_RST = COUNT_W'(1024);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

  // Status of the estimate divider
  typedef struct packed {
    logic busy;
    logic done;
  } pes_div_stat_t;

endpackage

// ===== rtl/pes_in_if.sv =====
// Input channel: load or search beats with valid/ready handshake.
// Depends on pes_pkg for field widths.
interface pes_in_if;
  import pes_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [INDEX_W-1:0]        element_index;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, command, element_index, value, input ready);
  modport sink   (input valid, command, element_index, value, output ready);
endinterface

// ===== rtl/pes_out_if.sv =====
// Output channel: one result beat per search, valid/ready handshake.
// Depends on pes_pkg for field widths.
interface pes_out_if;
  import pes_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [INDEX_W-1:0] position;
  logic [COUNT_W-1:0] attempts;

  modport source (output valid, found, position, attempts, input ready);
  modport sink   (input valid, found, position, attempts, output ready);
endinterface

// ===== rtl/pes_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pes_div.sv =====
// Serial estimate unit: floor(diff * n / span) for diff < span, one
// doubling or one addition per cycle through a shared add/reduce stage.
// Depends on pes_pkg for the status struct.
module pes_div #(
  parameter int ELEMENT_WIDTH = pes_pkg::ELEMENT_WIDTH_DEF,
  parameter int CNT_W         = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ELEMENT_WIDTH-1:0]   diff,
  input  logic [ELEMENT_WIDTH-1:0]   span,
  input  logic [CNT_W-1:0]           n,
  output logic [CNT_W-1:0]           quot,
  output pes_pkg::pes_div_stat_t     stat
);
  import pes_pkg::*;

  localparam int EW    = ELEMENT_WIDTH;
  localparam int BIT_W = (CNT_W > 1) ? $clog2(CNT_W) : 1;

  typedef enum logic [1:0] {D_IDLE, D_DBL, D_ADD} dstate_t;

  dstate_t          state;
  logic [EW-1:0]    rem;
  logic [BIT_W-1:0] bit_idx;
  logic             done;

  logic [EW-1:0] addend;
  logic [EW:0]   sum;
  logic [EW:0]   red;
  logic          ge;
  logic [EW-1:0] rem_next;

  // Shared unit: add, then reduce by span once (remainder stays below span)
  always_comb begin
    addend   = (state == D_ADD) ? diff : rem;
    sum      = {1'b0, rem} + {1'b0, addend};
    red      = sum - {1'b0, span};
    ge       = ~red[EW];
    rem_next = ge ? red[EW-1:0] : sum[EW-1:0];
  end

  // Sequencer: walk the bits of n from the top, double then maybe add
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            rem     <= '0;
            quot    <= '0;
            bit_idx <= BIT_W'(CNT_W - 1);
            state   <= D_DBL;
          end
        end
        D_DBL: begin
          rem  <= rem_next;
          quot <= {quot[CNT_W-2:0], 1'b0} + CNT_W'(ge);
          if (n[bit_idx]) begin
            state <= D_ADD;
          end else if (bit_idx == '0) begin
            state <= D_IDLE;
            done  <= 1'b1;
          end else begin
            bit_idx <= bit_idx - 1'b1;
          end
        end
        D_ADD: begin
          rem  <= rem_next;
          quot <= quot + CNT_W'(ge);
          if (bit_idx == '0) begin
            state <= D_IDLE;
            done  <= 1'b1;
          end else begin
            bit_idx <= bit_idx - 1'b1;
            state   <= D_DBL;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != D_IDLE);
  assign stat.done = done;

endmodule

// ===== rtl/proportional_estimate_search.sv =====
// Top level of the proportional estimate search: element store, sequencer,
// serial estimate unit. Depends on pes_pkg, pes_in_if, pes_out_if, pes_ram, pes_div.
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+-----------------------------------------
//  in_ch     | in  | valid/ready  | command, element_index, value
//  out_ch    | out | valid/ready  | found, position, attempts
//  cfg       | in  | cfg_write    | cfg_data = used_count
//
// A search makes two store reads for the end elements, runs the serial divider
// at one doubling or addition per cycle when the estimate needs a division,
// then makes one store read per probed element.
// Input ready is low while a search runs; a finished result waits in the
// output register while loads and the next search are taken.
// Synchronous reset clears control state; the store is undefined until written.
module proportional_estimate_search #(
  parameter int STORE_DEPTH   = pes_pkg::STORE_DEPTH_DEF,
  parameter int ELEMENT_WIDTH = pes_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [pes_pkg::COUNT_W-1:0]  cfg_data,
  pes_in_if.sink                       in_ch,
  pes_out_if.source                    out_ch
);
  import pes_pkg::*;

  localparam int EW    = ELEMENT_WIDTH;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_LAST, S_DIV, S_PROBE, S_CMP, S_SCAN, S_EMIT
  } state_t;

  state_t               state;
  logic [COUNT_W-1:0]   used_count;
  logic signed [EW-1:0] key;
  logic signed [EW-1:0] first;
  logic [EW-1:0]        diff;
  logic [EW-1:0]        span;
  logic [IDX_W-1:0]     est;
  logic [IDX_W-1:0]     cur;
  logic                 down;
  logic [CNT_W-1:0]     tries;
  logic [IDX_W-1:0]     pos;
  logic                 found_r;

  logic [CNT_W-1:0]     n_eff;
  logic [IDX_W-1:0]     last_idx;
  logic                 in_acc;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  logic [EW-1:0]        ram_rdata;
  logic signed [EW-1:0] elem;
  logic signed [EW-1:0] in_elem;
  logic [EW-1:0]        diff_c;
  logic [EW-1:0]        span_c;
  logic                 trivial;
  logic                 need_div;
  logic                 cmp_down;
  logic [IDX_W-1:0]     est_step;
  logic [IDX_W-1:0]     cur_step;
  logic                 scan_end;
  logic                 out_free;
  logic [CNT_W-1:0]     div_q;
  pes_div_stat_t        div_stat;

  // Effective element count: zero acts as one, clamp at the store depth
  always_comb begin
    if (used_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(used_count) > 32'(STORE_DEPTH)) begin
      n_eff = CNT_W'(STORE_DEPTH);
    end else begin
      n_eff = CNT_W'(used_count);
    end
    last_idx = IDX_W'(n_eff - CNT_W'(1));
  end

  assign in_acc   = in_ch.valid & in_ch.ready;
  assign in_elem  = EW'(in_ch.value);
  assign ram_we   = in_acc && (in_ch.command == CMD_LOAD) &&
                    (32'(in_ch.element_index) < 32'(STORE_DEPTH));
  assign elem     = ram_rdata;
  assign out_free = ~out_ch.valid | out_ch.ready;

  // Estimate setup from the end elements
  always_comb begin
    diff_c   = EW'(key - first);
    span_c   = EW'(elem - first);
    trivial  = (key <= first) || (elem <= first);
    need_div = (state == S_LAST) && !trivial && (diff_c < span_c);
  end

  // Scan direction and neighbor addresses
  always_comb begin
    cmp_down = (elem > key);
    est_step = cmp_down ? est - 1'b1 : est + 1'b1;
    cur_step = down ? cur - 1'b1 : cur + 1'b1;
    scan_end = down ? (cur == '0) : (cur == last_idx);
  end

  // Store read address per state
  always_comb begin
    case (state)
      S_FIRST: ram_raddr = last_idx;
      S_PROBE: ram_raddr = est;
      S_CMP:   ram_raddr = est_step;
      S_SCAN:  ram_raddr = cur_step;
      default: ram_raddr = '0;
    endcase
  end

  pes_ram #(
    .WIDTH (EW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_ch.element_index)),
    .wdata (in_elem),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pes_div #(
    .ELEMENT_WIDTH (EW),
    .CNT_W         (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (need_div),
    .diff  (diff),
    .span  (span),
    .n     (n_eff),
    .quot  (div_q),
    .stat  (div_stat)
  );

  assign in_ch.ready = (state == S_IDLE);

  // Sequencer, configuration register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used_count   <= USED_COUNT_RST;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        used_count <= cfg_data;
      end
      // Raise valid when a result leaves the sequencer, drop it after its beat
      if ((state == S_EMIT) && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && (in_ch.command == CMD_SEARCH)) begin
            key   <= in_elem;
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          first <= elem;
          state <= S_LAST;
        end
        S_LAST: begin
          diff <= diff_c;
          span <= span_c;
          if (trivial) begin
            est   <= '0;
            state <= S_PROBE;
          end else if (diff_c >= span_c) begin
            est   <= last_idx;
            state <= S_PROBE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            est   <= IDX_W'(div_q);
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          state <= S_CMP;
        end
        S_CMP: begin
          tries   <= CNT_W'(1);
          pos     <= est;
          down    <= cmp_down;
          found_r <= (elem == key);
          if ((elem == key) || (cmp_down && est == '0) ||
              (!cmp_down && est == last_idx)) begin
            state <= S_EMIT;
          end else begin
            cur   <= est_step;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          tries   <= tries + 1'b1;
          pos     <= cur;
          found_r <= (elem == key);
          if ((elem == key) || scan_end) begin
            state <= S_EMIT;
          end else begin
            cur <= cur_step;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_ch.found    <= found_r;
            out_ch.position <= INDEX_W'(pos);
            out_ch.attempts <= COUNT_W'(tries);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider runs only while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == S_DIV))
    else $error("divider busy outside the estimate phase");

  // A search beat always starts with the first-element read
  a_search_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.command == CMD_SEARCH) |=> (state == S_FIRST))
    else $error("search beat did not start the sequence");

  // The estimate lies inside the used part of the store
  a_est_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (est <= last_idx))
    else $error("estimate beyond the used elements");

  // The scan never probes more elements than are in use
  a_tries_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (tries <= n_eff))
    else $error("probe count exceeds the used count");

endmodule
